@@ rtl/core/kcr_pkg.sv @@
// Shared types, constants and microcode store of the key chord remapper.
package kcr_pkg;

   // Payload field widths
   localparam int CODE_W  = 8;
   localparam int VALUE_W = 2;
   localparam int INDEX_W = 5;

   // Key values and key states
   localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;
   localparam logic [VALUE_W-1:0] KEY_PRESS   = 2'd1;
   localparam logic [VALUE_W-1:0] KEY_REPEAT  = 2'd2;
   localparam logic [VALUE_W-1:0] KEY_ODD     = 2'd3;

   // Transaction kinds
   localparam logic ACTION_EVENT = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Microprogram addresses
   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] kcr_step_type;

   localparam kcr_step_type STEP_CLEAR     = 5'd0;
   localparam kcr_step_type STEP_IDLE      = 5'd1;
   localparam kcr_step_type STEP_EXEC      = 5'd2;
   localparam kcr_step_type STEP_SWEEP     = 5'd3;
   localparam kcr_step_type STEP_DECIDE    = 5'd4;
   localparam kcr_step_type STEP_DISPATCH  = 5'd5;
   localparam kcr_step_type STEP_PASS      = 5'd6;
   localparam kcr_step_type STEP_KP_MOD    = 5'd7;
   localparam kcr_step_type STEP_P_EMOD    = 5'd8;
   localparam kcr_step_type STEP_P_EKEY    = 5'd9;
   localparam kcr_step_type STEP_KR_EKEY   = 5'd10;
   localparam kcr_step_type STEP_KREL_EKEY = 5'd11;
   localparam kcr_step_type STEP_KREL_EMOD = 5'd12;
   localparam kcr_step_type STEP_KREL_MOD  = 5'd13;
   localparam kcr_step_type STEP_MP_MOD    = 5'd14;
   localparam kcr_step_type STEP_MP_KEY    = 5'd15;
   localparam kcr_step_type STEP_MREL_CODE = 5'd16;
   localparam kcr_step_type STEP_MREL_EMOD = 5'd17;
   localparam kcr_step_type STEP_MREL_EKEY = 5'd18;
   localparam kcr_step_type STEP_MREL_KEY  = 5'd19;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_COND,
      JMP_ALWAYS,
      JMP_MODE
   } kcr_jump_type;

   typedef enum logic [1:0] {
      COND_CLR_BUSY,
      COND_NO_ACCEPT,
      COND_IS_WRITE,
      COND_SWEEP_BUSY
   } kcr_cond_type;

   typedef enum logic [2:0] {
      SRC_CODE,
      SRC_TRIG_MOD,
      SRC_TRIG_KEY,
      SRC_EMIT_MOD,
      SRC_EMIT_KEY
   } kcr_src_type;

   typedef enum logic [1:0] {
      VAL_RELEASE,
      VAL_PRESS,
      VAL_REPEAT,
      VAL_EVENT
   } kcr_val_type;

   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_PASS,
      MODE_KEY_PRESS,
      MODE_KEY_REPEAT,
      MODE_KEY_RELEASE,
      MODE_MOD_PRESS,
      MODE_MOD_RELEASE
   } kcr_mode_type;

   // One chord table entry, without its valid bit
   typedef struct packed {
      logic [CODE_W-1:0] trig_mod;
      logic [CODE_W-1:0] trig_key;
      logic [CODE_W-1:0] emit_mod;
      logic [CODE_W-1:0] emit_key;
   } kcr_entry_type;

   // Control word of one microprogram step
   typedef struct packed {
      logic         ready;    // take a request transaction
      logic         clr_we;   // clear one key state entry
      logic         exec;     // apply table write or key state update
      logic         sweep;    // walk the chord table
      logic         decide;   // register outcome of the walk
      logic         emit;     // send one response transaction
      logic         opt;      // skip the emit when emit modifier is zero
      logic         last;     // final response of this request
      logic         cnt_clr;
      logic         cnt_inc;
      kcr_src_type  src;
      kcr_val_type  val;
      kcr_jump_type jump;
      kcr_cond_type cond;
      kcr_step_type target;
   } kcr_ucode_type;

   // Emit step helper: one response from a source and a value
   function automatic kcr_ucode_type emit_word(kcr_src_type src, kcr_val_type val,
                                               logic opt, logic last);
      kcr_ucode_type w;
      w      = '0;
      w.emit = 1'b1;
      w.src  = src;
      w.val  = val;
      w.opt  = opt;
      w.last = last;
      w.jump = JMP_NEXT;
      return w;
   endfunction

   // Microprogram store
   function automatic kcr_ucode_type ucode(kcr_step_type step);
      kcr_ucode_type w;
      w = '0;
      unique case (step)
         STEP_CLEAR: begin
            w.clr_we  = 1'b1;
            w.cnt_inc = 1'b1;
            w.jump    = JMP_COND;
            w.cond    = COND_CLR_BUSY;
            w.target  = STEP_CLEAR;
         end
         STEP_IDLE: begin
            w.ready   = 1'b1;
            w.cnt_clr = 1'b1;
            w.jump    = JMP_COND;
            w.cond    = COND_NO_ACCEPT;
            w.target  = STEP_IDLE;
         end
         STEP_EXEC: begin
            w.exec    = 1'b1;
            w.cnt_clr = 1'b1;
            w.jump    = JMP_COND;
            w.cond    = COND_IS_WRITE;
            w.target  = STEP_IDLE;
         end
         STEP_SWEEP: begin
            w.sweep   = 1'b1;
            w.cnt_inc = 1'b1;
            w.jump    = JMP_COND;
            w.cond    = COND_SWEEP_BUSY;
            w.target  = STEP_SWEEP;
         end
         STEP_DECIDE: begin
            w.decide = 1'b1;
            w.jump   = JMP_NEXT;
         end
         STEP_DISPATCH: begin
            w.jump = JMP_MODE;
         end
         STEP_PASS: begin
            w        = emit_word(SRC_CODE, VAL_EVENT, 1'b0, 1'b1);
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_KP_MOD:    w = emit_word(SRC_TRIG_MOD, VAL_RELEASE, 1'b0, 1'b0);
         STEP_P_EMOD:    w = emit_word(SRC_EMIT_MOD, VAL_PRESS, 1'b1, 1'b0);
         STEP_P_EKEY: begin
            w        = emit_word(SRC_EMIT_KEY, VAL_PRESS, 1'b0, 1'b1);
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_KR_EKEY: begin
            w        = emit_word(SRC_EMIT_KEY, VAL_REPEAT, 1'b0, 1'b1);
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_KREL_EKEY: w = emit_word(SRC_EMIT_KEY, VAL_RELEASE, 1'b0, 1'b0);
         STEP_KREL_EMOD: w = emit_word(SRC_EMIT_MOD, VAL_RELEASE, 1'b1, 1'b0);
         STEP_KREL_MOD: begin
            w        = emit_word(SRC_TRIG_MOD, VAL_PRESS, 1'b0, 1'b1);
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_MP_MOD:    w = emit_word(SRC_TRIG_MOD, VAL_RELEASE, 1'b0, 1'b0);
         STEP_MP_KEY: begin
            // share the tail of the key press sequence
            w        = emit_word(SRC_TRIG_KEY, VAL_RELEASE, 1'b0, 1'b0);
            w.jump   = JMP_ALWAYS;
            w.target = STEP_P_EMOD;
         end
         STEP_MREL_CODE: w = emit_word(SRC_CODE, VAL_RELEASE, 1'b0, 1'b0);
         STEP_MREL_EMOD: w = emit_word(SRC_EMIT_MOD, VAL_RELEASE, 1'b1, 1'b0);
         STEP_MREL_EKEY: w = emit_word(SRC_EMIT_KEY, VAL_RELEASE, 1'b0, 1'b0);
         STEP_MREL_KEY: begin
            w        = emit_word(SRC_TRIG_KEY, VAL_PRESS, 1'b0, 1'b1);
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Dispatch table: outcome of the walk to first emit step, or to idle when there is no outcome
   function automatic kcr_step_type mode_target(kcr_mode_type mode);
      kcr_step_type t;
      unique case (mode)
         MODE_PASS:        t = STEP_PASS;
         MODE_KEY_PRESS:   t = STEP_KP_MOD;
         MODE_KEY_REPEAT:  t = STEP_KR_EKEY;
         MODE_KEY_RELEASE: t = STEP_KREL_EKEY;
         MODE_MOD_PRESS:   t = STEP_MP_MOD;
         MODE_MOD_RELEASE: t = STEP_MREL_CODE;
         default:          t = STEP_IDLE;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/core/kcr_chan_if.sv @@
// Request and response channel interfaces of the key chord remapper.
interface kcr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [kcr_pkg::CODE_W-1:0]   key_code;
   logic [kcr_pkg::VALUE_W-1:0]  key_value;
   logic [kcr_pkg::INDEX_W-1:0]  entry_index;
   logic                         entry_valid;
   logic [kcr_pkg::CODE_W-1:0]   trigger_modifier;
   logic [kcr_pkg::CODE_W-1:0]   trigger_key;
   logic [kcr_pkg::CODE_W-1:0]   emit_modifier;
   logic [kcr_pkg::CODE_W-1:0]   emit_key;

   modport source (
      output valid, action, key_code, key_value, entry_index, entry_valid,
             trigger_modifier, trigger_key, emit_modifier, emit_key,
      input  ready
   );
   modport sink (
      input  valid, action, key_code, key_value, entry_index, entry_valid,
             trigger_modifier, trigger_key, emit_modifier, emit_key,
      output ready
   );
endinterface

interface kcr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kcr_pkg::CODE_W-1:0]   out_code;
   logic [kcr_pkg::VALUE_W-1:0]  out_value;
   logic                         last;

   modport source (
      output valid, out_code, out_value, last,
      input  ready
   );
   modport sink (
      input  valid, out_code, out_value, last,
      output ready
   );
endinterface

@@ rtl/core/key_chord_remapper.sv @@
// Key chord remapper top level: microcoded sequencer over key state and chord tables.
//
//   channel   direction  kind          contents
//   req_chan  in         valid/ready   key event or chord table write
//   rsp_chan  out        valid/ready   emitted key event, last flag
//
// After reset a clearing pass writes every key state table entry as released.
// A table write returns to idle after its execute step; a key event runs the chord
// table walk of one entry per cycle through a three stage read pipeline, then the
// decide and dispatch steps and one step per emit, a skipped emit modifier step included.
// An emit step holds while the response register is full and rsp_chan.ready is low;
// the final response waits there without blocking the next request.
module key_chord_remapper #(
   parameter int CHORD_ENTRIES = 32,
   parameter int CODE_COUNT    = 256
) (
   input logic        clock,
   input logic        reset,
   kcr_req_if.sink    req_chan,
   kcr_rsp_if.source  rsp_chan
);

   localparam int CW    = $clog2(CODE_COUNT);
   localparam int CXW   = CW + kcr_pkg::CODE_W;
   localparam int AW    = (CHORD_ENTRIES > 1) ? $clog2(CHORD_ENTRIES) : 1;
   localparam int AXW   = AW + kcr_pkg::INDEX_W;
   localparam int CNT_A = $clog2(CODE_COUNT);
   localparam int CNT_B = $clog2(CHORD_ENTRIES + 2);
   localparam int CNT_W = (CNT_A > CNT_B) ? CNT_A : CNT_B;

   // Sequencer
   kcr_pkg::kcr_step_type  step_ff, step_in;
   kcr_pkg::kcr_ucode_type cw;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   cond_true;
   logic                   accept;
   logic                   hold;
   logic                   skip;
   logic                   out_free;
   logic                   load;
   logic                   cw_emit;

   // Captured request
   logic                           item_action_ff;
   logic [kcr_pkg::CODE_W-1:0]     item_code_ff;
   logic [kcr_pkg::VALUE_W-1:0]    item_value_ff;
   logic [kcr_pkg::INDEX_W-1:0]    item_index_ff;
   logic                           item_on_ff;
   kcr_pkg::kcr_entry_type         item_ent_ff;

   // Key state table
   logic [kcr_pkg::VALUE_W-1:0] ks_mem [CODE_COUNT];
   logic                        ks_we;
   logic [CW-1:0]               ks_waddr;
   logic [kcr_pkg::VALUE_W-1:0] ks_wdata;
   logic [CXW-1:0]              code_wide, m_wide, k_wide;
   logic                        code_rng, m_rng, k_rng;
   logic [CW-1:0]               code_addr, m_addr, k_addr;
   logic [kcr_pkg::VALUE_W-1:0] ks_rd_m_ff, ks_rd_k_ff;
   logic                        rng_m_ff, rng_k_ff;

   // Chord table
   kcr_pkg::kcr_entry_type  ch_mem [CHORD_ENTRIES];
   logic [CHORD_ENTRIES-1:0] ch_vld_ff, ch_vld_in;
   logic [AXW-1:0]           idx_wide;
   logic                     idx_rng;
   logic [AW-1:0]            idx_addr;
   logic [AW-1:0]            rd_addr;
   logic                     issue;

   // Walk pipeline
   logic                   s1_act_ff, s1_act_in;
   logic                   s1_on_ff;
   kcr_pkg::kcr_entry_type s1_ent_ff;
   logic                   s2_act_ff;
   logic                   s2_on_ff;
   kcr_pkg::kcr_entry_type s2_ent_ff;
   logic [kcr_pkg::VALUE_W-1:0] st_m, st_k;
   logic                   khit, mhit;

   // Hit accumulators
   logic [1:0]                  kcnt_ff, kcnt_in, mcnt_ff, mcnt_in;
   kcr_pkg::kcr_entry_type      kent_ff, kent_in, ment_ff, ment_in;
   logic [kcr_pkg::VALUE_W-1:0] kst_ff, kst_in, mst_ff, mst_in;

   // Outcome
   kcr_pkg::kcr_mode_type       mode_ff, mode_in;
   kcr_pkg::kcr_entry_type      sel_ent_ff, use_ent;
   logic [kcr_pkg::VALUE_W-1:0] use_st;
   logic                        found, by_key;

   // Response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [kcr_pkg::CODE_W-1:0]  rsp_code_ff, emit_code;
   logic [kcr_pkg::VALUE_W-1:0] rsp_value_ff, emit_value;
   logic                        rsp_last_ff;

   // Fetch control word
   assign cw      = kcr_pkg::ucode(step_ff);
   assign cw_emit = cw.emit;

   assign req_chan.ready = cw.ready;
   assign accept         = req_chan.valid & cw.ready;

   // Branch condition
   always_comb begin
      case (cw.cond)
         kcr_pkg::COND_CLR_BUSY:   cond_true = (cnt_ff != CNT_W'(CODE_COUNT - 1));
         kcr_pkg::COND_NO_ACCEPT:  cond_true = !accept;
         kcr_pkg::COND_IS_WRITE:   cond_true = (item_action_ff == kcr_pkg::ACTION_WRITE);
         kcr_pkg::COND_SWEEP_BUSY: cond_true = (cnt_ff != CNT_W'(CHORD_ENTRIES + 1));
         default:                  cond_true = 1'b0;
      endcase
   end

   // Emit data path
   assign skip     = cw.opt & (sel_ent_ff.emit_mod == '0);
   assign out_free = !rsp_valid_ff | rsp_chan.ready;
   assign load     = cw.emit & !skip & out_free;
   assign hold     = cw.emit & !skip & !out_free;

   always_comb begin
      case (cw.src)
         kcr_pkg::SRC_TRIG_MOD: emit_code = sel_ent_ff.trig_mod;
         kcr_pkg::SRC_TRIG_KEY: emit_code = sel_ent_ff.trig_key;
         kcr_pkg::SRC_EMIT_MOD: emit_code = sel_ent_ff.emit_mod;
         kcr_pkg::SRC_EMIT_KEY: emit_code = sel_ent_ff.emit_key;
         default:               emit_code = item_code_ff;
      endcase
      case (cw.val)
         kcr_pkg::VAL_RELEASE: emit_value = kcr_pkg::KEY_RELEASE;
         kcr_pkg::VAL_PRESS:   emit_value = kcr_pkg::KEY_PRESS;
         kcr_pkg::VAL_REPEAT:  emit_value = kcr_pkg::KEY_REPEAT;
         default:              emit_value = item_value_ff;
      endcase
   end

   // Next step and step counter
   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else begin
         case (cw.jump)
            kcr_pkg::JMP_COND:   step_in = cond_true ? cw.target
                                                     : step_ff + kcr_pkg::kcr_step_type'(1);
            kcr_pkg::JMP_ALWAYS: step_in = cw.target;
            kcr_pkg::JMP_MODE:   step_in = kcr_pkg::mode_target(mode_ff);
            default:             step_in = step_ff + kcr_pkg::kcr_step_type'(1);
         endcase
      end
      if (cw.cnt_clr) begin
         cnt_in = '0;
      end else if (cw.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= kcr_pkg::STEP_CLEAR;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         item_action_ff       <= req_chan.action;
         item_code_ff         <= req_chan.key_code;
         item_value_ff        <= req_chan.key_value;
         item_index_ff        <= req_chan.entry_index;
         item_on_ff           <= req_chan.entry_valid;
         item_ent_ff.trig_mod <= req_chan.trigger_modifier;
         item_ent_ff.trig_key <= req_chan.trigger_key;
         item_ent_ff.emit_mod <= req_chan.emit_modifier;
         item_ent_ff.emit_key <= req_chan.emit_key;
      end
   end

   // Key state addressing; codes beyond the table read as released
   always_comb begin
      code_wide = CXW'(item_code_ff);
      m_wide    = CXW'(s1_ent_ff.trig_mod);
      k_wide    = CXW'(s1_ent_ff.trig_key);
      code_rng  = code_wide < CXW'(CODE_COUNT);
      m_rng     = m_wide < CXW'(CODE_COUNT);
      k_rng     = k_wide < CXW'(CODE_COUNT);
      code_addr = code_rng ? code_wide[CW-1:0] : '0;
      m_addr    = m_rng ? m_wide[CW-1:0] : '0;
      k_addr    = k_rng ? k_wide[CW-1:0] : '0;
      ks_we     = cw.clr_we |
                  (cw.exec & (item_action_ff == kcr_pkg::ACTION_EVENT) & code_rng);
      ks_waddr  = cw.clr_we ? cnt_ff[CW-1:0] : code_addr;
      ks_wdata  = cw.clr_we ? kcr_pkg::KEY_RELEASE : item_value_ff;
   end

   always_ff @(posedge clock) begin
      if (ks_we) begin
         ks_mem[ks_waddr] <= ks_wdata;
      end
      ks_rd_m_ff <= ks_mem[m_addr];
      ks_rd_k_ff <= ks_mem[k_addr];
      rng_m_ff   <= m_rng;
      rng_k_ff   <= k_rng;
   end

   // Chord table write; out of range indexes are dropped
   always_comb begin
      idx_wide  = AXW'(item_index_ff);
      idx_rng   = idx_wide < AXW'(CHORD_ENTRIES);
      idx_addr  = idx_wide[AW-1:0];
      ch_vld_in = ch_vld_ff;
      if (cw.exec && item_action_ff == kcr_pkg::ACTION_WRITE && idx_rng) begin
         ch_vld_in[idx_addr] = item_on_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_vld_ff <= '0;
      end else begin
         ch_vld_ff <= ch_vld_in;
      end
   end

   // Walk stage one: read one chord entry per cycle
   assign rd_addr   = cnt_ff[AW-1:0];
   assign issue     = cw.sweep & (cnt_ff < CNT_W'(CHORD_ENTRIES));
   assign s1_act_in = issue;

   always_ff @(posedge clock) begin
      if (cw.exec && item_action_ff == kcr_pkg::ACTION_WRITE && idx_rng) begin
         ch_mem[idx_addr] <= item_ent_ff;
      end
      if (issue) begin
         s1_ent_ff <= ch_mem[rd_addr];
         s1_on_ff  <= ch_vld_ff[rd_addr];
      end
      s2_ent_ff <= s1_ent_ff;
      s2_on_ff  <= s1_on_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_act_ff <= 1'b0;
         s2_act_ff <= 1'b0;
      end else begin
         s1_act_ff <= s1_act_in;
         s2_act_ff <= s1_act_ff;
      end
   end

   // Walk stage three: count key and modifier matches
   always_comb begin
      st_m = rng_m_ff ? ks_rd_m_ff : kcr_pkg::KEY_RELEASE;
      st_k = rng_k_ff ? ks_rd_k_ff : kcr_pkg::KEY_RELEASE;
      khit = s2_act_ff & s2_on_ff & (s2_ent_ff.trig_key == item_code_ff) &
             (st_m != kcr_pkg::KEY_RELEASE);
      mhit = s2_act_ff & s2_on_ff & (s2_ent_ff.trig_mod == item_code_ff) &
             (st_k != kcr_pkg::KEY_RELEASE);
      kcnt_in = kcnt_ff;
      mcnt_in = mcnt_ff;
      kent_in = kent_ff;
      ment_in = ment_ff;
      kst_in  = kst_ff;
      mst_in  = mst_ff;
      if (cw.exec) begin
         kcnt_in = '0;
         mcnt_in = '0;
      end else begin
         if (khit) begin
            kcnt_in = (kcnt_ff == 2'd2) ? kcnt_ff : kcnt_ff + 2'd1;
            kent_in = s2_ent_ff;
            kst_in  = st_m;
         end
         if (mhit) begin
            mcnt_in = (mcnt_ff == 2'd2) ? mcnt_ff : mcnt_ff + 2'd1;
            ment_in = s2_ent_ff;
            mst_in  = st_k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kcnt_ff <= '0;
         mcnt_ff <= '0;
      end else begin
         kcnt_ff <= kcnt_in;
         mcnt_ff <= mcnt_in;
      end
      kent_ff <= kent_in;
      ment_ff <= ment_in;
      kst_ff  <= kst_in;
      mst_ff  <= mst_in;
   end

   // Pick the outcome: a single key match wins over a single modifier match
   always_comb begin
      found   = 1'b1;
      by_key  = 1'b1;
      use_ent = kent_ff;
      use_st  = kst_ff;
      if (kcnt_ff == 2'd1) begin
         by_key = 1'b1;
      end else if (mcnt_ff == 2'd1) begin
         by_key  = 1'b0;
         use_ent = ment_ff;
         use_st  = mst_ff;
      end else begin
         found = 1'b0;
      end

      if (!found || use_st == kcr_pkg::KEY_RELEASE) begin
         mode_in = kcr_pkg::MODE_PASS;
      end else if (use_st == kcr_pkg::KEY_ODD) begin
         mode_in = kcr_pkg::MODE_NONE;
      end else if (by_key) begin
         case (item_value_ff)
            kcr_pkg::KEY_PRESS:   mode_in = kcr_pkg::MODE_KEY_PRESS;
            kcr_pkg::KEY_REPEAT:  mode_in = kcr_pkg::MODE_KEY_REPEAT;
            kcr_pkg::KEY_RELEASE: mode_in = kcr_pkg::MODE_KEY_RELEASE;
            default:              mode_in = kcr_pkg::MODE_NONE;
         endcase
      end else begin
         case (item_value_ff)
            kcr_pkg::KEY_PRESS:   mode_in = kcr_pkg::MODE_MOD_PRESS;
            kcr_pkg::KEY_RELEASE: mode_in = kcr_pkg::MODE_MOD_RELEASE;
            default:              mode_in = kcr_pkg::MODE_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= kcr_pkg::MODE_NONE;
      end else if (cw.decide) begin
         mode_ff <= mode_in;
      end
      if (cw.decide) begin
         sel_ent_ff <= use_ent;
      end
   end

   // Response register: load on emit, drop once taken
   assign rsp_valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_code_ff  <= emit_code;
         rsp_value_ff <= emit_value;
         rsp_last_ff  <= cw.last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_code  = rsp_code_ff;
   assign rsp_chan.out_value = rsp_value_ff;
   assign rsp_chan.last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cw_emit))
      else $error("response raised outside an emit step");

   a_write_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (step_ff == kcr_pkg::STEP_EXEC && item_action_ff == kcr_pkg::ACTION_WRITE)
      |=> step_ff == kcr_pkg::STEP_IDLE)
      else $error("table write did not return to idle");

   a_none_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (step_ff == kcr_pkg::STEP_DISPATCH && mode_ff == kcr_pkg::MODE_NONE)
      |=> step_ff == kcr_pkg::STEP_IDLE)
      else $error("silent outcome emitted a response");

   a_accept_while_sweep_clear: assert property (@(posedge clock) disable iff (reset)
      (step_ff == kcr_pkg::STEP_SWEEP) |-> !req_chan.ready && !s2_act_ff ||
      (cnt_ff > CNT_W'(1)))
      else $error("walk pipeline active at start of sweep");
`endif

endmodule
